>>> rtl/core/kaa_pkg.sv
// Shared types and constants for the k-means assignment/accumulate block.
package kaa_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_POINT = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 1'b1;

	// cluster index as carried through the distance pipeline (up to 64 clusters)
	localparam int KIDX_W = 6;
	localparam int DIST_W = 37;

	typedef struct packed {
		op_t                operation;
		logic [4:0]         cluster;
		logic [3:0]         feature;
		logic signed [15:0] value;
	} kaa_item_t;

	typedef struct packed {
		logic               kind;
		logic [4:0]         cluster_res;
		logic signed [31:0] feature_sum;
		logic [31:0]        point_count;
	} kaa_res_t;

	typedef struct packed {
		logic              first;
		logic              last;
		logic [KIDX_W-1:0] k;
	} dist_tag_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_ASSIGN,
		ST_ADRAIN,
		ST_ACCUM,
		ST_ADONE,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/core/kaa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kaa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/kaa_dist.sv
// Squared-distance pipeline: difference and square, then accumulate and best-so-far compare.
module kaa_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        v_s1,
	input  kaa_pkg::dist_tag_t          tag_s1,
	input  logic signed [15:0]          cval,
	input  logic signed [15:0]          pval,
	output logic [kaa_pkg::KIDX_W-1:0]  best_k,
	output logic                        busy
);
	import kaa_pkg::*;

	logic signed [16:0] diff;
	logic signed [33:0] prod;
	logic [32:0]        sq_s2;
	dist_tag_t          tag_s2;
	logic               v_s2;
	logic [DIST_W-1:0]  acc_q;
	logic [DIST_W-1:0]  best_d_q;
	logic [KIDX_W-1:0]  best_k_q;
	logic [DIST_W-1:0]  dsum;

	assign diff = {pval[15], pval} - {cval[15], cval};
	assign prod = diff * diff;
	assign dsum = (tag_s2.first ? '0 : acc_q) + DIST_W'(sq_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			best_d_q <= '1;
			best_k_q <= '0;
		end else begin
			v_s2 <= v_s1;
			if (start) begin
				best_d_q <= '1;
				best_k_q <= '0;
			end else if (v_s2 && tag_s2.last && (dsum < best_d_q)) begin
				// strict less: ties keep the lower cluster
				best_d_q <= dsum;
				best_k_q <= tag_s2.k;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sq_s2  <= prod[32:0];
			tag_s2 <= tag_s1;
		end
		if (v_s2)
			acc_q <= dsum;
	end

	assign best_k = best_k_q;
	assign busy   = v_s2;

endmodule

>>> rtl/core/kmeans_assign_accumulate.sv
// Top level of the k-means assignment step with per-cluster sum and count totals.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+-----------------------
//  item    | item_valid item_ready item       | item_valid & item_ready
//  result  | res_valid res_ready res          | res_valid & res_ready
//  config  | cfg_valid cfg_ready cfg_index/data| cfg_valid & cfg_ready
//
// Centroid loads and non-completing point features leave the block idle; a
// totals read passes through the read state. A completing feature walks
// nk*nf centroid words through the centroid RAM read port (one per cycle),
// drains a 2-deep distance pipeline, then read-modify-writes the nf words of
// the winning row in the sums RAM. Reset and every clear run a zeroing sweep
// over all CLUSTERS_MAX*FEATURES_MAX sums RAM words with item_ready low.
// A stalled result only holds the states that need the output register.
module kmeans_assign_accumulate #(
	parameter int FEATURES_MAX = 16,
	parameter int CLUSTERS_MAX = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_ready,
	input  kaa_pkg::kaa_item_t               item,
	output logic                             res_valid,
	input  logic                             res_ready,
	output kaa_pkg::kaa_res_t                res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kaa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kaa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import kaa_pkg::*;

	localparam int FW    = (FEATURES_MAX > 1) ? $clog2(FEATURES_MAX) : 1;
	localparam int CW    = (CLUSTERS_MAX > 1) ? $clog2(CLUSTERS_MAX) : 1;
	localparam int DEPTH = CLUSTERS_MAX * FEATURES_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NFW   = $clog2(FEATURES_MAX + 1);
	localparam int NKW   = $clog2(CLUSTERS_MAX + 1);

	state_t state_q, state_d;

	// config registers
	logic [4:0] nf_q;
	logic [5:0] nk_q;
	logic [NFW-1:0] nf_eff;
	logic [NKW-1:0] nk_eff;
	logic [FW-1:0]  nf_last;
	logic [CW-1:0]  nk_last;

	// walk counters and clear sweep
	logic [FW-1:0] f_q;
	logic [CW-1:0] k_q;
	logic [AW-1:0] clr_q;

	logic signed [15:0] pbuf_q [FEATURES_MAX];

	// read pipeline stage
	logic               dv_s1;
	dist_tag_t          tag_s1;
	logic signed [15:0] pv_s1;
	logic               av_s1;
	logic               afirst_s1;
	logic [AW-1:0]      aaddr_s1;

	logic [31:0] cnt_new_q;
	logic        rd_inside_q;
	logic [4:0]  rd_cl_q;

	logic     res_valid_q;
	kaa_res_t res_q;

	logic              acc;
	logic              in_range;
	logic              feat_ok;
	logic              completes;
	logic [AW-1:0]     item_addr;
	logic [AW-1:0]     walk_addr;
	logic [AW-1:0]     sum_addr;
	logic              out_free;
	logic              f_end;
	logic              k_end;
	logic              dist_start;
	logic [KIDX_W-1:0] best_k;
	logic              dist_busy;

	logic [15:0] cent_rdata;
	logic        sum_we, sum_re;
	logic [AW-1:0] sum_waddr, sum_raddr;
	logic [31:0] sum_wdata, sum_rdata;
	logic        cnt_we, cnt_re;
	logic [CW-1:0] cnt_waddr, cnt_raddr;
	logic [31:0] cnt_wdata, cnt_rdata;

	// effective register values, saturated into their legal ranges
	always_comb begin
		if (nf_q == '0)
			nf_eff = NFW'(1);
		else if (32'(nf_q) > FEATURES_MAX)
			nf_eff = NFW'(FEATURES_MAX);
		else
			nf_eff = NFW'(nf_q);
		if (nk_q == '0)
			nk_eff = NKW'(1);
		else if (32'(nk_q) > CLUSTERS_MAX)
			nk_eff = NKW'(CLUSTERS_MAX);
		else
			nk_eff = NKW'(nk_q);
	end
	assign nf_last = FW'(nf_eff - NFW'(1));
	assign nk_last = CW'(nk_eff - NKW'(1));

	assign item_ready = (state_q == ST_IDLE);
	assign acc        = item_valid && item_ready;
	assign feat_ok    = 32'(item.feature) < FEATURES_MAX;
	assign in_range   = feat_ok && (32'(item.cluster) < CLUSTERS_MAX);
	assign completes  = feat_ok && (32'(item.feature) == 32'(nf_eff) - 1);
	assign item_addr  = AW'(32'(item.cluster) * FEATURES_MAX + 32'(item.feature));
	assign walk_addr  = AW'(32'(k_q) * FEATURES_MAX + 32'(f_q));
	assign sum_addr   = AW'(32'(best_k) * FEATURES_MAX + 32'(f_q));
	assign out_free   = !res_valid_q || res_ready;
	assign f_end      = (f_q == nf_last);
	assign k_end      = (k_q == nk_last);
	assign dist_start = acc && (item.operation == OP_POINT) && completes;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q <= 5'd16;
			nk_q <= 6'd32;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_FEATURES: nf_q <= cfg_data[4:0];
				REG_NUM_CLUSTERS: nk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next-state logic
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					unique case (item.operation)
						OP_READ:  state_d = ST_READ;
						OP_CLEAR: state_d = ST_CLEAR;
						OP_POINT: if (completes) state_d = ST_ASSIGN;
						default: ;
					endcase
				end
			end
			ST_READ: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			ST_ASSIGN: begin
				if (f_end && k_end)
					state_d = ST_ADRAIN;
			end
			ST_ADRAIN: begin
				if (!dv_s1 && !dist_busy)
					state_d = ST_ACCUM;
			end
			ST_ACCUM: begin
				if (f_end)
					state_d = ST_ADONE;
			end
			ST_ADONE: begin
				if (!av_s1)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	// counters and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			f_q   <= '0;
			k_q   <= '0;
			dv_s1 <= 1'b0;
			av_s1 <= 1'b0;
		end else begin
			dv_s1 <= (state_q == ST_ASSIGN);
			av_s1 <= (state_q == ST_ACCUM);
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + AW'(1);
			else
				clr_q <= '0;
			if (state_q == ST_ASSIGN) begin
				if (f_end) begin
					f_q <= '0;
					k_q <= k_end ? '0 : k_q + CW'(1);
				end else begin
					f_q <= f_q + FW'(1);
				end
			end else if (state_q == ST_ACCUM) begin
				f_q <= f_end ? '0 : f_q + FW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc && (item.operation == OP_POINT) && feat_ok)
			pbuf_q[FW'(item.feature)] <= item.value;
		if ((state_q == ST_ASSIGN) || (state_q == ST_ACCUM))
			pv_s1 <= pbuf_q[f_q];
		if (state_q == ST_ASSIGN) begin
			tag_s1.first <= (f_q == '0);
			tag_s1.last  <= f_end;
			tag_s1.k     <= KIDX_W'(k_q);
		end
		if (state_q == ST_ACCUM) begin
			afirst_s1 <= (f_q == '0);
			aaddr_s1  <= sum_addr;
		end
		if (av_s1 && afirst_s1)
			cnt_new_q <= cnt_rdata + 32'd1;
		if (acc) begin
			rd_inside_q <= in_range;
			rd_cl_q     <= item.cluster;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (((state_q == ST_READ) || (state_q == ST_EMIT)) && out_free)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_READ) && out_free) begin
			res_q.kind        <= KIND_READ;
			res_q.cluster_res <= rd_cl_q;
			res_q.feature_sum <= rd_inside_q ? sum_rdata : '0;
			res_q.point_count <= rd_inside_q ? cnt_rdata : '0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			res_q.kind        <= KIND_ASSIGN;
			res_q.cluster_res <= best_k[4:0];
			res_q.feature_sum <= '0;
			res_q.point_count <= cnt_new_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// centroid storage
	kaa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cent (
		.clk   (clk),
		.we    (acc && (item.operation == OP_LOAD) && in_range),
		.waddr (item_addr),
		.wdata (item.value),
		.re    (state_q == ST_ASSIGN),
		.raddr (walk_addr),
		.rdata (cent_rdata)
	);

	kaa_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.v_s1   (dv_s1),
		.tag_s1 (tag_s1),
		.cval   (cent_rdata),
		.pval   (pv_s1),
		.best_k (best_k),
		.busy   (dist_busy)
	);

	// sums: zeroing sweep, or read-modify-write of the winning cluster's row
	assign sum_we    = (state_q == ST_CLEAR) || av_s1;
	assign sum_waddr = (state_q == ST_CLEAR) ? clr_q : aaddr_s1;
	assign sum_wdata = (state_q == ST_CLEAR) ? '0 : sum_rdata + 32'(pv_s1);
	assign sum_re    = (state_q == ST_ACCUM) || (acc && (item.operation == OP_READ));
	assign sum_raddr = (state_q == ST_ACCUM) ? sum_addr : item_addr;

	kaa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_sums (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.re    (sum_re),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	// counts: cleared in the first CLUSTERS_MAX steps of the sweep
	assign cnt_we    = ((state_q == ST_CLEAR) && (32'(clr_q) < CLUSTERS_MAX))
		|| (av_s1 && afirst_s1);
	assign cnt_waddr = (state_q == ST_CLEAR) ? CW'(clr_q) : CW'(best_k);
	assign cnt_wdata = (state_q == ST_CLEAR) ? '0 : cnt_rdata + 32'd1;
	assign cnt_re    = ((state_q == ST_ACCUM) && (f_q == '0))
		|| (acc && (item.operation == OP_READ));
	assign cnt_raddr = (state_q == ST_ACCUM) ? CW'(best_k) : CW'(item.cluster);

	kaa_ram #(.WIDTH(32), .DEPTH(CLUSTERS_MAX)) u_cnts (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

endmodule

>>> rtl/core/kaa_checker.sv
// Port-level checks for the k-means block, bound to the top level.
module kaa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_ready,
	input kaa_pkg::kaa_item_t             item,
	input logic                           res_valid,
	input logic                           res_ready,
	input kaa_pkg::kaa_res_t              res,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [kaa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [kaa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kaa_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.operation == OP_CLEAR) |=> !item_ready)
		else $error("clear did not start sweep");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.operation == OP_READ) |=> !item_ready)
		else $error("read took no cycle for memory access");

	a_assign_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.kind == KIND_ASSIGN) |-> (res.feature_sum == '0))
		else $error("assignment result with nonzero sum");

endmodule

bind kmeans_assign_accumulate kaa_checker u_kaa_checker (.*);

>>> tb/tb_kmeans_assign_accumulate.sv
// Self-checking testbench for kmeans_assign_accumulate.
module tb_kmeans_assign_accumulate;
	import kaa_pkg::*;

	localparam int NF_MAX   = 16;
	localparam int NK_MAX   = 32;
	// longest quiet stretch: clear sweep plus a full 32x16 search
	localparam int SETTLE   = 1200;
	localparam int WDOG_LIM = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	kaa_item_t item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	kaa_res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	kmeans_assign_accumulate uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the block's state
	logic signed [15:0] centroids [NK_MAX*NF_MAX];
	logic signed [15:0] point_buf [NF_MAX];
	logic [31:0] sums [NK_MAX*NF_MAX];
	logic [31:0] counts [NK_MAX];
	logic [4:0] nf_reg = 5'd16;
	logic [5:0] nk_reg = 6'd32;

	kaa_res_t pending_results [$];
	int errors = 0;
	int sent = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int quiet = 0;

	// typed expectation for the directed row currently being sent
	bit typed_on = 0;
	kaa_res_t typed_res;

	typedef struct {
		kaa_item_t it;
		bit typed;
		kaa_res_t res;
	} stim_row_t;

	stim_row_t directed [$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// centroid load, assignment and totals update, totals read or clear for one accepted item
	function automatic bit predict_item(input kaa_item_t it, output kaa_res_t r);
		int nf, nk, best_k, idx;
		longint d_sq, best_d, diff;
		nf = (nf_reg < 1) ? 1 : (nf_reg > NF_MAX) ? NF_MAX : nf_reg;
		nk = (nk_reg < 1) ? 1 : (nk_reg > NK_MAX) ? NK_MAX : nk_reg;
		r = '0;
		case (it.operation)
			OP_LOAD: begin
				centroids[it.cluster*NF_MAX + it.feature] = it.value;
				return 0;
			end
			OP_POINT: begin
				point_buf[it.feature] = it.value;
				if (it.feature != nf - 1)
					return 0;
				best_d = 64'h1f_ffff_ffff;
				best_k = 0;
				for (int k = 0; k < nk; k++) begin
					d_sq = 0;
					for (int f = 0; f < nf; f++) begin
						diff = longint'(point_buf[f]) - longint'(centroids[k*NF_MAX + f]);
						d_sq += diff * diff;
					end
					if (d_sq < best_d) begin
						best_d = d_sq;
						best_k = k;
					end
				end
				counts[best_k] += 1;
				for (int f = 0; f < nf; f++)
					sums[best_k*NF_MAX + f] += 32'(signed'(point_buf[f]));
				r.kind = KIND_ASSIGN;
				r.cluster_res = best_k[4:0];
				r.point_count = counts[best_k];
				return 1;
			end
			OP_READ: begin
				idx = it.cluster*NF_MAX + it.feature;
				r.kind = KIND_READ;
				r.cluster_res = it.cluster;
				r.feature_sum = sums[idx];
				r.point_count = counts[it.cluster];
				return 1;
			end
			default: begin
				foreach (sums[i]) sums[i] = '0;
				foreach (counts[i]) counts[i] = '0;
				return 0;
			end
		endcase
	endfunction

	// accepted items feed the predictor; accepted results are checked in order
	always @(posedge clk) begin
		kaa_res_t r;
		kaa_res_t want;
		if (item_valid && item_ready) begin
			if (predict_item(item, r))
				pending_results.push_back(typed_on ? typed_res : r);
		end
		if (res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 64'(res.point_count), 64'(0));
			end else begin
				want = pending_results.pop_front();
				if (res.kind !== want.kind)
					report("kind", 64'(res.kind), 64'(want.kind));
				if (res.cluster_res !== want.cluster_res)
					report("cluster_res", 64'(res.cluster_res), 64'(want.cluster_res));
				if (res.feature_sum !== want.feature_sum)
					report("feature_sum", 64'(res.feature_sum), 64'(want.feature_sum));
				if (res.point_count !== want.point_count)
					report("point_count", 64'(res.point_count), 64'(want.point_count));
			end
		end
	end

	// watchdog: any transfer restarts the count
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WDOG_LIM) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= recv_stall);

	task automatic send_item(input kaa_item_t it);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic go_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// register writes only with the block drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		go_idle();
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_NUM_FEATURES) nf_reg = d[4:0];
		else nk_reg = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic kaa_item_t mk(input op_t op, input int cl, input int ft, input int v);
		kaa_item_t it;
		it.operation = op;
		it.cluster = cl[4:0];
		it.feature = ft[3:0];
		it.value = v[15:0];
		return it;
	endfunction

	function automatic logic [15:0] rand_val();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_row(input kaa_item_t it, input bit typed, input kaa_res_t r);
		stim_row_t row;
		row.it = it;
		row.typed = typed;
		row.res = r;
		directed.push_back(row);
	endtask

	task automatic random_phase(input int n_items);
		int nf, nk, target;
		kaa_item_t it;
		nf = (nf_reg < 1) ? 1 : (nf_reg > NF_MAX) ? NF_MAX : nf_reg;
		nk = (nk_reg < 1) ? 1 : (nk_reg > NK_MAX) ? NK_MAX : nk_reg;
		target = sent + n_items;
		while (sent < target) begin
			case ($urandom_range(19))
				0, 1: send_item(mk(OP_LOAD, $urandom_range(nk - 1), $urandom_range(NF_MAX - 1),
					rand_val()));
				2: send_item(mk(OP_LOAD, $urandom_range(31), $urandom_range(15), rand_val()));
				3, 4: send_item(mk(OP_READ, $urandom_range(31), $urandom_range(15), 0));
				5: if ($urandom_range(9) == 0) send_item(mk(OP_CLEAR, $urandom_range(31),
					$urandom_range(15), rand_val()));
				6: send_item(mk(OP_POINT, $urandom_range(31), $urandom_range(15), rand_val()));
				default: begin
					// well-formed point, features in order, last one completes it
					for (int f = 0; f < nf; f++)
						send_item(mk(OP_POINT, $urandom_range(31), f, rand_val()));
				end
			endcase
		end
	endtask

	initial begin
		kaa_res_t zr;
		kaa_res_t none;
		none = '0;
		zr = '0;
		zr.kind = KIND_READ;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (sums[i]) sums[i] = '0;
		foreach (counts[i]) counts[i] = '0;

		// directed: totals are zero after reset and after a clear
		zr.cluster_res = 5'd0;
		add_row(mk(OP_READ, 0, 0, 0), 1, zr);
		zr.cluster_res = 5'd31;
		add_row(mk(OP_READ, 31, 15, 0), 1, zr);
		add_row(mk(OP_CLEAR, 9, 3, 16'h7fff), 0, none);
		zr.cluster_res = 5'd7;
		add_row(mk(OP_READ, 7, 2, 0), 1, zr);
		foreach (directed[i]) begin
			typed_on = directed[i].typed;
			typed_res = directed[i].res;
			send_item(directed[i].it);
		end
		typed_on = 0;
		directed.delete();

		// fill every centroid word and the whole point buffer before any search
		for (int k = 0; k < NK_MAX; k++)
			for (int f = 0; f < NF_MAX; f++)
				send_item(mk(OP_LOAD, k, f, rand_val()));
		for (int f = 0; f < NF_MAX; f++)
			send_item(mk(OP_POINT, 0, f, (f % 2) ? 32767 : -32768));

		// directed: one feature, two clusters, tie goes low, extremes, feature past the point
		write_reg(REG_NUM_FEATURES, 6'd1);
		write_reg(REG_NUM_CLUSTERS, 6'd2);
		add_row(mk(OP_LOAD, 0, 0, 100), 0, none);
		add_row(mk(OP_LOAD, 1, 0, 100), 0, none);
		add_row(mk(OP_POINT, 0, 0, 100), 0, none);
		add_row(mk(OP_POINT, 3, 0, -32768), 0, none);
		add_row(mk(OP_POINT, 0, 5, 7), 0, none);
		add_row(mk(OP_LOAD, 1, 0, -32768), 0, none);
		add_row(mk(OP_LOAD, 0, 0, 32767), 0, none);
		add_row(mk(OP_POINT, 0, 0, 32767), 0, none);
		add_row(mk(OP_POINT, 0, 0, -32768), 0, none);
		add_row(mk(OP_POINT, 0, 0, 0), 0, none);
		add_row(mk(OP_READ, 0, 0, 0), 0, none);
		add_row(mk(OP_READ, 1, 0, 0), 0, none);
		add_row(mk(OP_READ, 1, 5, 0), 0, none);
		foreach (directed[i]) send_item(directed[i].it);
		// saturation: zero and oversized register values
		write_reg(REG_NUM_FEATURES, 6'd0);
		write_reg(REG_NUM_CLUSTERS, 6'd0);
		send_item(mk(OP_POINT, 0, 0, 1234));
		write_reg(REG_NUM_FEATURES, 6'd31);
		write_reg(REG_NUM_CLUSTERS, 6'd63);
		for (int f = 0; f < NF_MAX; f++)
			send_item(mk(OP_POINT, 0, f, rand_val()));

		// random phases under three idling profiles
		for (int p = 0; p < 3; p++) begin
			send_idle = (p == 0) ? 35 : (p == 1) ? 62 : 0;
			recv_stall = (p == 0) ? 62 : (p == 1) ? 35 : 0;
			write_reg(REG_NUM_FEATURES, 6'($urandom_range(1, 4)));
			write_reg(REG_NUM_CLUSTERS, 6'($urandom_range(1, 32)));
			random_phase(130);
			write_reg(REG_NUM_FEATURES, (p == 1) ? 6'd16 : 6'($urandom_range(1, 16)));
			write_reg(REG_NUM_CLUSTERS, (p == 2) ? 6'd1 : 6'($urandom_range(2, 32)));
			random_phase(120);
			write_reg(REG_NUM_FEATURES, 6'($urandom_range(0, 63)));
			write_reg(REG_NUM_CLUSTERS, 6'($urandom_range(0, 63)));
			random_phase(50);
		end

		go_idle();
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
